// ----- rtl/cell_voltage_pack_stats_macros.svh -----
// Assertion helpers for the cell voltage pack statistics block.
`ifndef CELL_VOLTAGE_PACK_STATS_MACROS_SVH
`define CELL_VOLTAGE_PACK_STATS_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define CVPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define CVPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cvps_pkg.sv -----
package cvps_pkg;

  localparam int MAX_CELLS      = 256;
  localparam int CELLS_PER_DEV  = 16;
  localparam int CNT_W          = $clog2(MAX_CELLS + 2);
  localparam int DEV_W          = 5;
  localparam int IDX_W          = 8;
  localparam int VOLT_W         = 17;
  localparam int RAW_W          = 16;
  localparam int SUM_W          = 25;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic signed [VOLT_W-1:0] VOLT_OFFSET = 17'sd10000;
  localparam logic signed [VOLT_W-1:0] MIN_RESET   = 17'sd42767;
  localparam logic signed [VOLT_W-1:0] MAX_RESET   = -17'sd22768;
  localparam logic signed [SUM_W-1:0]  SUM_HI      = 25'sh0FFFFFF;
  localparam logic signed [SUM_W-1:0]  SUM_LO      = 25'sh1000000;
  localparam logic [CNT_W-1:0]         CELLS_SAT   = CNT_W'(MAX_CELLS + 1);
  localparam logic [CNT_W-1:0]         IDX_LIMIT   = CNT_W'(MAX_CELLS - 1);
  localparam logic [DEV_W-1:0]         DEV_RESET   = 5'd1;

  typedef struct packed {
    logic signed [VOLT_W-1:0] volt;
    logic                     last;
  } cvps_item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } cvps_qstat_t;

endpackage

// ----- rtl/cell_voltage_pack_stats.sv -----
// Channel   Handshake              Payload
// in_       in_valid / in_ready    in_raw_code, in_pack_last
// out_      out_valid / out_ready  out_cell_index .. out_pack_valid
// cfg_      cfg_we                 cfg_wdata (device count)
//
// One request per cycle unless the queue is full; results pass the queue and output register.
// The front converts the code and pushes into a four-entry queue; the back
// updates sum, min, max and count and loads the output register.
// in_ready drops only when the queue is full; reset clears queue, totals and
// sets the device count to one.
module cell_voltage_pack_stats
  import cvps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [DEV_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [RAW_W-1:0]  in_raw_code,
  input  logic                     in_pack_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_cell_index,
  output logic signed [VOLT_W-1:0] out_cell_voltage,
  output logic                     out_pack_done,
  output logic signed [SUM_W-1:0]  out_pack_sum,
  output logic signed [VOLT_W-1:0] out_pack_min,
  output logic signed [VOLT_W-1:0] out_pack_max,
  output logic                     out_pack_valid
);

  cvps_qstat_t q_stat;
  cvps_item_t  push_item;
  cvps_item_t  head_item;
  logic        q_push;
  logic        q_pop;

  cvps_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_raw_code  (in_raw_code),
    .in_pack_last (in_pack_last),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  cvps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  cvps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_item           (head_item),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_index   (out_cell_index),
    .out_cell_voltage (out_cell_voltage),
    .out_pack_done    (out_pack_done),
    .out_pack_sum     (out_pack_sum),
    .out_pack_min     (out_pack_min),
    .out_pack_max     (out_pack_max),
    .out_pack_valid   (out_pack_valid)
  );

endmodule

// ----- rtl/cvps_front.sv -----
module cvps_front
  import cvps_pkg::*;
(
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw_code,
  input  logic                    in_pack_last,
  input  cvps_qstat_t             q_stat,
  output logic                    q_push,
  output cvps_item_t              q_item
);

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // fold the 1.5 V offset into the code: exact in 150 uV units
  always_comb begin
    q_item.volt = {in_raw_code[RAW_W-1], in_raw_code} + VOLT_OFFSET;
    q_item.last = in_pack_last;
  end

endmodule

// ----- rtl/cvps_queue.sv -----
module cvps_queue
  import cvps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cvps_item_t  push_item,
  input  logic        pop,
  output cvps_item_t  head_item,
  output cvps_qstat_t stat
);

  cvps_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item     = mem_r[rd_ptr_r];
  assign stat.full     = (count_r == QCNT_W'(QDEPTH));
  assign stat.nonempty = (count_r != '0);

endmodule

// ----- rtl/cvps_back.sv -----
module cvps_back
  import cvps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [DEV_W-1:0]         cfg_wdata,
  input  cvps_item_t               q_item,
  input  cvps_qstat_t              q_stat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_cell_index,
  output logic signed [VOLT_W-1:0] out_cell_voltage,
  output logic                     out_pack_done,
  output logic signed [SUM_W-1:0]  out_pack_sum,
  output logic signed [VOLT_W-1:0] out_pack_min,
  output logic signed [VOLT_W-1:0] out_pack_max,
  output logic                     out_pack_valid
);

  logic [DEV_W-1:0]         device_count_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [VOLT_W-1:0] min_r, min_nxt;
  logic signed [VOLT_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]         cells_r, cells_nxt;
  logic signed [SUM_W:0]    sum_wide;
  logic [IDX_W-1:0]         idx;
  logic                     match;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [VOLT_W-1:0] volt_r;
  logic                     done_r;
  logic signed [SUM_W-1:0]  psum_r;
  logic signed [VOLT_W-1:0] pmin_r;
  logic signed [VOLT_W-1:0] pmax_r;
  logic                     pvalid_r;

  assign q_pop = q_stat.nonempty && (!out_valid_r || out_ready);

  always_comb begin
    sum_wide = {sum_r[SUM_W-1], sum_r}
             + {{(SUM_W + 1 - VOLT_W){q_item.volt[VOLT_W-1]}}, q_item.volt};
    // clamp on a carry into the guard bit
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_LO : SUM_HI;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    min_nxt   = (q_item.volt < min_r) ? q_item.volt : min_r;
    max_nxt   = (q_item.volt > max_r) ? q_item.volt : max_r;
    cells_nxt = (cells_r == CELLS_SAT) ? cells_r : cells_r + CNT_W'(1);
    idx       = (cells_r > IDX_LIMIT) ? IDX_LIMIT[IDX_W-1:0] : cells_r[IDX_W-1:0];
    match     = (cells_nxt == CNT_W'(device_count_r) * CNT_W'(CELLS_PER_DEV));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r <= DEV_RESET;
    end else if (cfg_we) begin
      device_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      min_r   <= MIN_RESET;
      max_r   <= MAX_RESET;
      cells_r <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        sum_r   <= '0;
        min_r   <= MIN_RESET;
        max_r   <= MAX_RESET;
        cells_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        cells_r <= cells_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_r    <= idx;
      volt_r   <= q_item.volt;
      done_r   <= q_item.last;
      psum_r   <= q_item.last ? sum_nxt : '0;
      pmin_r   <= q_item.last ? min_nxt : '0;
      pmax_r   <= q_item.last ? max_nxt : '0;
      pvalid_r <= q_item.last && match;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_index   = idx_r;
  assign out_cell_voltage = volt_r;
  assign out_pack_done    = done_r;
  assign out_pack_sum     = psum_r;
  assign out_pack_min     = pmin_r;
  assign out_pack_max     = pmax_r;
  assign out_pack_valid   = pvalid_r;

endmodule

// ----- rtl/cvps_checker.sv -----
`include "cell_voltage_pack_stats_macros.svh"

module cvps_checker
  import cvps_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [IDX_W-1:0]         out_cell_index,
  input logic signed [VOLT_W-1:0] out_cell_voltage,
  input logic                     out_pack_done,
  input logic signed [SUM_W-1:0]  out_pack_sum,
  input logic signed [VOLT_W-1:0] out_pack_min,
  input logic signed [VOLT_W-1:0] out_pack_max,
  input logic                     out_pack_valid
);

  `CVPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_voltage) && $stable(out_pack_sum) && $stable(out_cell_index), "stalled result changed")

  `CVPS_ASSERT_NOW(a_mid_zero, clk, rst_n, out_valid && !out_pack_done, out_pack_sum == '0 && out_pack_min == '0 && out_pack_max == '0 && !out_pack_valid, "open pack shows totals")

  // a matching pack holds a whole number of chips, so its last index ends in 15
  `CVPS_ASSERT_NOW(a_valid_idx, clk, rst_n, out_valid && out_pack_valid, out_pack_done && out_cell_index[3:0] == 4'hF, "valid pack with odd cell count")

  `CVPS_ASSERT_NOW(a_min_max, clk, rst_n, out_valid && out_pack_done, out_pack_min <= out_pack_max && out_cell_voltage >= out_pack_min && out_cell_voltage <= out_pack_max, "pack min/max inconsistent")

endmodule

bind cell_voltage_pack_stats cvps_checker u_cvps_checker (.*);

// ----- tb/tb_cell_voltage_pack_stats.sv -----
module tb_cell_voltage_pack_stats;
  import cvps_pkg::*;

  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [IDX_W-1:0]         cell_index;
    logic signed [VOLT_W-1:0] cell_voltage;
    logic                     pack_done;
    logic signed [SUM_W-1:0]  pack_sum;
    logic signed [VOLT_W-1:0] pack_min;
    logic signed [VOLT_W-1:0] pack_max;
    logic                     pack_valid;
  } cell_result_t;

  typedef struct {
    logic signed [RAW_W-1:0] raw;
    logic                    is_last;
    bit                      typed;
    cell_result_t            want;
  } stim_row_t;

  typedef enum {FILL_ANY, FILL_TOP, FILL_BOTTOM} fill_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [DEV_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [RAW_W-1:0]  in_raw_code = '0;
  logic                     in_pack_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_cell_index;
  logic signed [VOLT_W-1:0] out_cell_voltage;
  logic                     out_pack_done;
  logic signed [SUM_W-1:0]  out_pack_sum;
  logic signed [VOLT_W-1:0] out_pack_min;
  logic signed [VOLT_W-1:0] out_pack_max;
  logic                     out_pack_valid;

  // predicted block state
  logic [DEV_W-1:0] devices = DEV_RESET;
  int               acc_sum;
  int               acc_min;
  int               acc_max;
  int               cells_counted;

  cell_result_t expected_results[$];
  int           mismatch_count = 0;
  bit           quiet = 1'b0;
  bit           hold_request = 1'b0;

  // directed requests at the reset device count of one
  stim_row_t directed_rows [0:20] = '{
    '{16'sd0, 1'b1, 1'b1,
      '{8'd0, 17'sd10000, 1'b1, 25'sd10000, 17'sd10000, 17'sd10000, 1'b0}},
    '{16'sd32767, 1'b0, 1'b1, '{8'd0, 17'sd42767, 1'b0, '0, '0, '0, 1'b0}},
    '{-16'sd32768, 1'b1, 1'b1,
      '{8'd1, -17'sd22768, 1'b1, 25'sd19999, -17'sd22768, 17'sd42767, 1'b0}},
    '{-16'sd1, 1'b0, 1'b0, '0},
    '{16'sd1, 1'b0, 1'b0, '0},
    '{-16'sd10000, 1'b0, 1'b0, '0},
    '{-16'sd10001, 1'b0, 1'b0, '0},
    '{16'sd32767, 1'b0, 1'b0, '0},
    '{-16'sd32768, 1'b0, 1'b0, '0},
    '{16'sd21845, 1'b0, 1'b0, '0},
    '{-16'sd21846, 1'b0, 1'b0, '0},
    '{16'sd255, 1'b0, 1'b0, '0},
    '{-16'sd256, 1'b0, 1'b0, '0},
    '{16'sd4096, 1'b0, 1'b0, '0},
    '{-16'sd4097, 1'b0, 1'b0, '0},
    '{16'sd12345, 1'b0, 1'b0, '0},
    '{-16'sd12345, 1'b0, 1'b0, '0},
    '{16'sd100, 1'b0, 1'b0, '0},
    '{16'sd0, 1'b1, 1'b0, '0},
    '{-16'sd10000, 1'b0, 1'b1, '{8'd0, 17'sd0, 1'b0, '0, '0, '0, 1'b0}},
    '{-16'sd10001, 1'b1, 1'b1,
      '{8'd1, -17'sd1, 1'b1, -25'sd1, -17'sd1, 17'sd0, 1'b0}}
  };

  cell_voltage_pack_stats uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_code      (in_raw_code),
    .in_pack_last     (in_pack_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_index   (out_cell_index),
    .out_cell_voltage (out_cell_voltage),
    .out_pack_done    (out_pack_done),
    .out_pack_sum     (out_pack_sum),
    .out_pack_min     (out_pack_min),
    .out_pack_max     (out_pack_max),
    .out_pack_valid   (out_pack_valid)
  );

  always #2 clk = ~clk;

  function automatic void clear_totals();
    acc_sum = 0;
    acc_min = int'(MIN_RESET);
    acc_max = int'(MAX_RESET);
    cells_counted = 0;
  endfunction

  function automatic cell_result_t predict_cell(logic signed [RAW_W-1:0] raw,
                                                logic is_last);
    cell_result_t r;
    int volt;
    int total;
    r = '0;
    volt = int'(raw) + int'(VOLT_OFFSET);
    r.cell_index = IDX_W'((cells_counted > MAX_CELLS - 1) ? MAX_CELLS - 1 : cells_counted);
    r.cell_voltage = VOLT_W'(volt);
    r.pack_done = is_last;
    total = acc_sum + volt;
    if (total > int'(SUM_HI)) total = int'(SUM_HI);
    if (total < int'(SUM_LO)) total = int'(SUM_LO);
    acc_sum = total;
    if (volt < acc_min) acc_min = volt;
    if (volt > acc_max) acc_max = volt;
    if (cells_counted < MAX_CELLS + 1) cells_counted++;
    if (is_last) begin
      r.pack_sum = SUM_W'(acc_sum);
      r.pack_min = VOLT_W'(acc_min);
      r.pack_max = VOLT_W'(acc_max);
      r.pack_valid = (cells_counted == CELLS_PER_DEV * int'(devices));
      clear_totals();
    end
    return r;
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_idle();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // enter at any time; leaves valid high right after the accepting edge
  task automatic send_cell(logic signed [RAW_W-1:0] raw, logic is_last, bit typed,
                           cell_result_t want);
    int gap;
    cell_result_t predicted;
    gap = pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_code <= raw;
    in_pack_last <= is_last;
    do @(posedge clk); while (!in_ready);
    predicted = predict_cell(raw, is_last);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_device_count(logic [DEV_W-1:0] n);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    devices = n;
  endtask

  task automatic send_pack(int cells, fill_t fill);
    logic signed [RAW_W-1:0] raw;
    for (int i = 0; i < cells; i++) begin
      case (fill)
        FILL_TOP:    raw = RAW_W'($urandom_range(32000, 32767));
        FILL_BOTTOM: raw = RAW_W'(-32768 + int'($urandom_range(0, 160)));
        default: begin
          case ($urandom_range(0, 9))
            0:       raw = 16'sh7FFF;
            1:       raw = 16'sh8000;
            2:       raw = -16'sd10000;
            default: raw = RAW_W'($urandom());
          endcase
        end
      endcase
      send_cell(raw, i == cells - 1, 1'b0, '0);
    end
  endtask

  // mostly packs of the configured size, some off by one, some arbitrary
  task automatic run_packs(int budget);
    int sent;
    int cells;
    int r;
    int full_len;
    sent = 0;
    full_len = CELLS_PER_DEV * int'(devices);
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) cells = full_len;
      else if (r < 70) cells = $urandom_range(0, 1) ? full_len + 1 : full_len - 1;
      else cells = $urandom_range(1, 40);
      if (cells < 1 || cells > MAX_CELLS + CELLS_PER_DEV) cells = $urandom_range(1, 40);
      send_pack(cells, FILL_ANY);
      sent += cells;
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  // result side: random backpressure plus one long hold-off on request
  initial begin
    int ready_stall;
    ready_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (ready_stall > 0) begin
        out_ready <= 1'b0;
        ready_stall--;
      end else begin
        out_ready <= 1'b1;
        ready_stall = pick_idle();
      end
    end
  end

  initial begin
    cell_result_t got;
    cell_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_cell_index, out_cell_voltage, out_pack_done, out_pack_sum,
                out_pack_min, out_pack_max, out_pack_valid};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("unexpected result: index %0d voltage %0d", got.cell_index,
                     got.cell_voltage);
        end else begin
          want = expected_results.pop_front();
          if (got.cell_index !== want.cell_index ||
              got.cell_voltage !== want.cell_voltage ||
              got.pack_done !== want.pack_done ||
              got.pack_sum !== want.pack_sum ||
              got.pack_min !== want.pack_min ||
              got.pack_max !== want.pack_max ||
              got.pack_valid !== want.pack_valid) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
              $display({"mismatch: index %0d/%0d voltage %0d/%0d done %0d/%0d ",
                        "sum %0d/%0d min %0d/%0d max %0d/%0d valid %0d/%0d (exp/got)"},
                       want.cell_index, got.cell_index,
                       want.cell_voltage, got.cell_voltage,
                       want.pack_done, got.pack_done,
                       want.pack_sum, got.pack_sum,
                       want.pack_min, got.pack_min,
                       want.pack_max, got.pack_max,
                       want.pack_valid, got.pack_valid);
          end
        end
      end
    end
  end

  // end the run if neither channel moves for too long
  initial begin
    int stale;
    stale = 0;
    while (stale < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stale = 0;
      else stale++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clear_totals();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_cell(directed_rows[i].raw, directed_rows[i].is_last, directed_rows[i].typed,
                directed_rows[i].want);

    set_device_count(5'd1);
    quiet = 1'b1;
    run_packs(40);
    quiet = 1'b0;

    // keep offering requests while the result side holds off
    set_device_count(5'd2);
    hold_request = 1'b1;
    run_packs(80);

    // full pack, then an overfull one that saturates the sum high
    set_device_count(5'd16);
    send_pack(MAX_CELLS, FILL_ANY);
    send_pack(400, FILL_TOP);

    // zero devices: nothing can be valid
    set_device_count(5'd0);
    run_packs(20);

    set_device_count(5'd31);
    run_packs(20);

    set_device_count(5'd17);
    send_pack(20, FILL_ANY);

    set_device_count(DEV_W'($urandom_range(1, 4)));
    run_packs(40);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
